@@ rtl/core/postfix_expression_evaluator_assert.svh @@
// Assertion macros for the postfix evaluator.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define PEV_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pev assertion failed");
`define PEV_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pev assertion failed");
`else
`define PEV_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define PEV_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/pev_pkg.sv @@
package pev_pkg;

	localparam int STACK_DEPTH = 128;
	localparam int PTR_W       = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int DATA_W      = 32;
	localparam int CNT_W       = $clog2(DATA_W);

	localparam logic [7:0] TOK_PLUS  = 8'h2B;
	localparam logic [7:0] TOK_MINUS = 8'h2D;
	localparam logic [7:0] TOK_STAR  = 8'h2A;
	localparam logic [7:0] CHR_UA    = 8'd65;
	localparam logic [7:0] CHR_UZ    = 8'd90;
	localparam logic [7:0] CHR_LA    = 8'd97;
	localparam logic [7:0] CHR_LZ    = 8'd122;

	typedef enum logic [1:0] {
		STAT_OK,
		STAT_UNDER,
		STAT_OVER,
		STAT_DIVZ
	} pev_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_DIV,
		S_DIV_WB,
		S_EMIT
	} pev_state_t;

	typedef struct packed {
		logic        latch;
		logic        push;
		logic        op_read;
		logic        alu_wb;
		logic        divz_wb;
		logic        div_start;
		logic        div_step;
		logic        div_wb;
		logic        emit;
		logic        flag;
		pev_status_t flag_code;
	} pev_cmd_t;

	typedef struct packed {
		logic in_last;
		logic tok_letter;
		logic sp_full;
		logic sp_lt2;
		logic last_q;
		logic op_div;
		logic b_zero;
		logic div_last;
		logic out_free;
	} pev_sts_t;

	function automatic logic is_letter(logic [7:0] t);
		return ((t >= CHR_UA) && (t <= CHR_UZ)) || ((t >= CHR_LA) && (t <= CHR_LZ));
	endfunction

endpackage

@@ rtl/core/postfix_expression_evaluator.sv @@
// Postfix expression evaluator: one token per input transaction, letters push the
// attached 32-bit value, '+', '-', '*' combine the top two entries, any other code
// divides (truncating, divide by zero gives 0 and status 3). The top of stack lives
// in a register and the entries below it in a 128-entry single-read memory, so a
// letter needs no memory read, '+', '-', '*' need one, and division reads the
// memory, runs the radix-2 restoring divider, then writes back. A transaction
// marked last adds a state that pops the top into the output register, and waits there
// only while the previous result has not been taken. Errors are sticky per expression;
// the stack and status clear after each result.
module postfix_expression_evaluator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         token,
	input  logic signed [31:0] operand_value,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] result,
	output logic [1:0]         status
);
	import pev_pkg::*;

	pev_cmd_t          cmd;
	pev_sts_t          sts;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [DATA_W-1:0] mem_wdata;
	logic [ADDR_W-1:0] mem_raddr;
	logic [DATA_W-1:0] mem_rdata;

	pev_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pev_stack u_stack (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	pev_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.token         (token),
		.operand_value (operand_value),
		.last          (last),
		.cmd           (cmd),
		.sts           (sts),
		.mem_we        (mem_we),
		.mem_waddr     (mem_waddr),
		.mem_wdata     (mem_wdata),
		.mem_raddr     (mem_raddr),
		.mem_rdata     (mem_rdata),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.result        (result),
		.status        (status)
	);

endmodule

@@ rtl/core/pev_stack.sv @@
module pev_stack (
	input  logic                       clk,
	input  logic                       we,
	input  logic [pev_pkg::ADDR_W-1:0] waddr,
	input  logic [pev_pkg::DATA_W-1:0] wdata,
	input  logic [pev_pkg::ADDR_W-1:0] raddr,
	output logic [pev_pkg::DATA_W-1:0] rdata
);
	import pev_pkg::*;

	logic [DATA_W-1:0] mem [STACK_DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/pev_ctrl.sv @@
module pev_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pev_pkg::pev_sts_t sts,
	output pev_pkg::pev_cmd_t cmd
);
	import pev_pkg::*;

	pev_state_t state_q;
	pev_state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_nx  = sts.in_last ? S_EMIT : S_IDLE;
					if (sts.tok_letter) begin
						if (sts.sp_full) begin
							cmd.flag      = 1'b1;
							cmd.flag_code = STAT_OVER;
						end else begin
							cmd.push = 1'b1;
						end
					end else if (sts.sp_lt2) begin
						cmd.flag      = 1'b1;
						cmd.flag_code = STAT_UNDER;
					end else begin
						cmd.op_read = 1'b1;
						state_nx    = S_READ;
					end
				end
			end
			S_READ: begin
				if (sts.op_div) begin
					if (sts.b_zero) begin
						cmd.flag      = 1'b1;
						cmd.flag_code = STAT_DIVZ;
						cmd.divz_wb   = 1'b1;
						state_nx      = sts.last_q ? S_EMIT : S_IDLE;
					end else begin
						cmd.div_start = 1'b1;
						state_nx      = S_DIV;
					end
				end else begin
					cmd.alu_wb = 1'b1;
					state_nx   = sts.last_q ? S_EMIT : S_IDLE;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_nx = S_DIV_WB;
				end
			end
			S_DIV_WB: begin
				cmd.div_wb = 1'b1;
				state_nx   = sts.last_q ? S_EMIT : S_IDLE;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/core/pev_datapath.sv @@
`include "postfix_expression_evaluator_assert.svh"
module pev_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [7:0]                 token,
	input  logic signed [31:0]         operand_value,
	input  logic                       last,
	input  pev_pkg::pev_cmd_t          cmd,
	output pev_pkg::pev_sts_t          sts,
	output logic                       mem_we,
	output logic [pev_pkg::ADDR_W-1:0] mem_waddr,
	output logic [pev_pkg::DATA_W-1:0] mem_wdata,
	output logic [pev_pkg::ADDR_W-1:0] mem_raddr,
	input  logic [pev_pkg::DATA_W-1:0] mem_rdata,
	input  logic                       out_ready,
	output logic                       out_valid,
	output logic signed [31:0]         result,
	output logic [1:0]                 status
);
	import pev_pkg::*;

	logic [PTR_W-1:0]  sp_q;
	pev_status_t       err_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] tos_q;
	logic [7:0]        op_q;
	logic              last_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] dvs_q;
	logic              neg_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W-1:0] result_q;
	pev_status_t       status_q;

	logic [PTR_W-1:0]  sp_m1;
	logic [PTR_W-1:0]  sp_m2;
	logic              sp_zero;
	logic [DATA_W-1:0] alu;
	logic [DATA_W-1:0] mag_a;
	logic [DATA_W-1:0] mag_b;
	logic [DATA_W-1:0] rem_sh;
	logic              ge;
	logic [DATA_W-1:0] rem_nx;
	logic [DATA_W-1:0] quo_nx;

	assign sp_m1   = sp_q - PTR_W'(1);
	assign sp_m2   = sp_q - PTR_W'(2);
	assign sp_zero = (sp_q == '0);

	assign mem_we    = cmd.push && !sp_zero;
	assign mem_waddr = sp_m1[ADDR_W-1:0];
	assign mem_wdata = tos_q;
	assign mem_raddr = sp_m2[ADDR_W-1:0];

	always_comb begin
		case (op_q)
			TOK_PLUS:  alu = mem_rdata + tos_q;
			TOK_MINUS: alu = mem_rdata - tos_q;
			TOK_STAR:  alu = mem_rdata * tos_q;
			default:   alu = '0;
		endcase
	end

	assign mag_a  = mem_rdata[DATA_W-1] ? (DATA_W'(0) - mem_rdata) : mem_rdata;
	assign mag_b  = tos_q[DATA_W-1] ? (DATA_W'(0) - tos_q) : tos_q;
	assign rem_sh = {rem_q[DATA_W-2:0], quo_q[DATA_W-1]};
	assign ge     = (rem_sh >= dvs_q);
	assign rem_nx = ge ? (rem_sh - dvs_q) : rem_sh;
	assign quo_nx = {quo_q[DATA_W-2:0], ge};

	assign sts.in_last    = last;
	assign sts.tok_letter = is_letter(token);
	assign sts.sp_full    = (sp_q >= PTR_W'(STACK_DEPTH));
	assign sts.sp_lt2     = (sp_q < PTR_W'(2));
	assign sts.last_q     = last_q;
	assign sts.op_div     = !((op_q == TOK_PLUS) || (op_q == TOK_MINUS) || (op_q == TOK_STAR));
	assign sts.b_zero     = (tos_q == '0);
	assign sts.div_last   = (cnt_q == '0);
	assign sts.out_free   = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q        <= '0;
			err_q       <= STAT_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				sp_q <= '0;
			end else if (cmd.push) begin
				sp_q <= sp_q + PTR_W'(1);
			end else if (cmd.alu_wb || cmd.divz_wb || cmd.div_wb) begin
				sp_q <= sp_m1;
			end
			if (cmd.emit) begin
				err_q <= STAT_OK;
			end else if (cmd.flag && (err_q == STAT_OK)) begin
				err_q <= cmd.flag_code;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q   <= token;
			last_q <= last;
		end
		if (cmd.push) begin
			tos_q <= operand_value;
		end else if (cmd.alu_wb) begin
			tos_q <= alu;
		end else if (cmd.divz_wb) begin
			tos_q <= '0;
		end else if (cmd.div_wb) begin
			tos_q <= neg_q ? (DATA_W'(0) - quo_q) : quo_q;
		end
		if (cmd.div_start) begin
			quo_q <= mag_a;
			rem_q <= '0;
			dvs_q <= mag_b;
			neg_q <= mem_rdata[DATA_W-1] ^ tos_q[DATA_W-1];
			cnt_q <= CNT_W'(DATA_W - 1);
		end else if (cmd.div_step) begin
			quo_q <= quo_nx;
			rem_q <= rem_nx;
			cnt_q <= cnt_q - CNT_W'(1);
		end
		if (cmd.emit) begin
			result_q <= sp_zero ? '0 : tos_q;
			status_q <= (sp_zero && (err_q == STAT_OK)) ? STAT_UNDER : err_q;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;
	assign status    = status_q;

	`PEV_ASSERT_NOW(a_sp_bound, clk, arst_n, 1'b1, sp_q <= PTR_W'(STACK_DEPTH))
	`PEV_ASSERT_NXT(a_emit_clears, clk, arst_n, cmd.emit, (sp_q == '0) && (err_q == STAT_OK))
	`PEV_ASSERT_NXT(a_push_tos, clk, arst_n, cmd.push, tos_q == $past(operand_value))
	`PEV_ASSERT_NOW(a_emit_slot, clk, arst_n, cmd.emit, !out_valid_q || out_ready)
	`PEV_ASSERT_NOW(a_op_depth, clk, arst_n, cmd.op_read, sp_q >= PTR_W'(2))
	`PEV_ASSERT_NOW(a_rem_range, clk, arst_n, cmd.div_step, rem_q < dvs_q)

endmodule

@@ bench/postfix_expression_evaluator_tb.sv @@
module postfix_expression_evaluator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pev_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int RANDOM_TOKENS = 1000;

	// non-letter codes; everything outside +, -, * divides
	localparam logic [7:0] TOK_SLASH    = 8'h2F;
	localparam logic [7:0] TOK_AT       = 8'd64;
	localparam logic [7:0] TOK_LBRACKET = 8'd91;
	localparam logic [7:0] TOK_BACKTICK = 8'd96;
	localparam logic [7:0] TOK_LBRACE   = 8'd123;
	localparam logic [7:0] TOK_NUL      = 8'h00;
	localparam logic [7:0] TOK_ALL_ONES = 8'hFF;

	localparam logic [31:0] INT_MIN = 32'h8000_0000;
	localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;

	typedef struct {
		logic [7:0]  tok;
		logic [31:0] val;
		logic        last;
		logic        drain;
	} token_item_t;

	typedef struct {
		logic [31:0] value;
		pev_status_t status;
	} eval_outcome_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [7:0]         token = '0;
	logic signed [31:0] operand_value = '0;
	logic               last = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] result;
	logic [1:0]         status;

	token_item_t   token_q[$];
	eval_outcome_t result_q[$];
	token_item_t   cur;

	logic [31:0]   stk_model [STACK_DEPTH];
	int unsigned   sp_model;
	pev_status_t   err_model;

	int cycle;
	int n_planned;
	int n_accepted;
	int n_fail;
	int n_status [4];
	int gap_left;
	int stall_left;
	logic quiet;

	assign quiet = ((cycle / 4000) % 5) == 1;

	postfix_expression_evaluator u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.token         (token),
		.operand_value (operand_value),
		.last          (last),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.result        (result),
		.status        (status)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic logic is_operand_code(logic [7:0] t);
		return t inside {[CHR_UA:CHR_UZ], [CHR_LA:CHR_LZ]};
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 8);
		return $urandom_range(20, 60);
	endfunction

	function automatic void note_error(pev_status_t code);
		if (err_model == STAT_OK)
			err_model = code;
	endfunction

	// stack machine: one token in, at most one outcome out
	task automatic apply_token(input token_item_t it);
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] r;
		logic [31:0] ma;
		logic [31:0] mb;
		eval_outcome_t o;
		if (is_operand_code(it.tok)) begin
			if (sp_model >= STACK_DEPTH) begin
				note_error(STAT_OVER);
			end else begin
				stk_model[sp_model] = it.val;
				sp_model++;
			end
		end else if (sp_model < 2) begin
			note_error(STAT_UNDER);
		end else begin
			b = stk_model[sp_model - 1];
			a = stk_model[sp_model - 2];
			case (it.tok)
				TOK_PLUS: r = a + b;
				TOK_MINUS: r = a - b;
				TOK_STAR: r = a * b;
				default: begin
					ma = a[31] ? 32'd0 - a : a;
					mb = b[31] ? 32'd0 - b : b;
					if (mb == 0) begin
						note_error(STAT_DIVZ);
						r = '0;
					end else begin
						r = ma / mb;
						if (a[31] != b[31])
							r = 32'd0 - r;
					end
				end
			endcase
			stk_model[sp_model - 2] = r;
			sp_model--;
		end
		if (it.last) begin
			o.value = '0;
			if (sp_model == 0)
				note_error(STAT_UNDER);
			else
				o.value = stk_model[sp_model - 1];
			o.status = err_model;
			result_q.push_back(o);
			sp_model = 0;
			err_model = STAT_OK;
		end
	endtask

	task automatic add_token(input logic [7:0] t, input logic [31:0] v, input logic l,
		input logic d);
		token_item_t it;
		it.tok = t;
		it.val = v;
		it.last = l;
		it.drain = d;
		token_q.push_back(it);
		n_planned++;
	endtask

	function automatic logic [7:0] rand_letter();
		int r;
		r = $urandom_range(0, 51);
		return (r < 26) ? CHR_UA + 8'(r) : CHR_LA + 8'(r - 26);
	endfunction

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 9))
			0: return INT_MIN;
			1: return INT_MAX;
			2: return '0;
			3: return '1;
			4, 5, 6: return 32'($signed($urandom_range(0, 40)) - 20);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [7:0] rand_op();
		logic [7:0] t;
		case ($urandom_range(0, 19))
			0, 1, 2, 3, 4: return TOK_PLUS;
			5, 6, 7, 8, 9: return TOK_MINUS;
			10, 11, 12, 13: return TOK_STAR;
			14, 15, 16: return TOK_SLASH;
			default: begin
				do
					t = 8'($urandom_range(0, 255));
				while (is_operand_code(t));
				return t;
			end
		endcase
	endfunction

	// well-formed expression; sometimes the tail operator is dropped so entries are left over
	task automatic gen_expression(input int n_operands, input logic drain);
		token_item_t seq[$];
		token_item_t it;
		int depth;
		int left;
		depth = 0;
		left = n_operands;
		while (left > 0 || depth > 1) begin
			it.last = 1'b0;
			it.drain = 1'b0;
			it.val = rand_value();
			if (left > 0 && (depth < 2 || $urandom_range(0, 1) == 1)) begin
				it.tok = rand_letter();
				depth++;
				left--;
			end else begin
				it.tok = rand_op();
				depth--;
			end
			seq.push_back(it);
		end
		if (seq.size() > 2 && $urandom_range(0, 7) == 0 && !is_operand_code(seq[$].tok))
			void'(seq.pop_back());
		seq[$].last = 1'b1;
		seq[0].drain = drain;
		foreach (seq[i])
			add_token(seq[i].tok, seq[i].val, seq[i].last, seq[i].drain);
	endtask

	task automatic gen_deep(input int n_push, input int n_ops);
		for (int i = 0; i < n_push; i++)
			add_token(rand_letter(), rand_value(), 1'b0, 1'b0);
		for (int i = 0; i < n_ops; i++)
			add_token(rand_op(), $urandom, i == n_ops - 1, 1'b0);
	endtask

	task automatic gen_noise(input int n);
		for (int i = 0; i < n; i++)
			add_token(8'($urandom_range(0, 255)), $urandom,
				(i == n - 1) || ($urandom_range(0, 5) == 0), 1'b0);
	endtask

	always @(posedge clk or negedge arst_n) begin : driver
		token_item_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			token <= '0;
			operand_value <= '0;
			last <= 1'b0;
			gap_left <= 0;
		end else begin
			if (in_valid && in_ready) begin
				apply_token(cur);
				n_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (token_q.size() != 0 &&
					!(token_q[0].drain && result_q.size() != 0)) begin
					nxt = token_q.pop_front();
					cur = nxt;
					in_valid <= 1'b1;
					token <= nxt.tok;
					operand_value <= nxt.val;
					last <= nxt.last;
					gap_left <= quiet ? 0 : idle_len();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		eval_outcome_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					$error("unexpected transaction: result %0d, status %0d", result, status);
					n_fail++;
				end else begin
					want = result_q.pop_front();
					n_status[want.status]++;
					if (result !== want.value) begin
						$error("result: expected %0d, got %0d", $signed(want.value), result);
						n_fail++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						n_fail++;
					end
				end
			end
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!quiet && $urandom_range(0, 2) == 0)
					stall_left <= idle_len();
			end
		end
	end

	initial begin
		int stop_at;
		int r;
		sp_model = 0;
		err_model = STAT_OK;

		// MIN / -1 wraps
		add_token(CHR_UA, INT_MIN, 1'b0, 1'b0);
		add_token(CHR_LZ, '1, 1'b0, 1'b0);
		add_token(TOK_SLASH, $urandom, 1'b1, 1'b0);
		// divide by zero
		add_token(CHR_UZ, 32'd7, 1'b0, 1'b0);
		add_token(CHR_LA, '0, 1'b0, 1'b0);
		add_token(TOK_AT, $urandom, 1'b1, 1'b0);
		// last token on empty stack
		add_token(TOK_PLUS, $urandom, 1'b1, 1'b0);
		// underflow stays sticky over a later divide by zero
		add_token("B", 32'd5, 1'b0, 1'b0);
		add_token(TOK_MINUS, $urandom, 1'b0, 1'b0);
		add_token("C", 32'd3, 1'b0, 1'b0);
		add_token(TOK_STAR, $urandom, 1'b0, 1'b0);
		add_token("D", '0, 1'b0, 1'b0);
		add_token(TOK_SLASH, $urandom, 1'b1, 1'b0);
		// add wraps
		add_token("M", INT_MAX, 1'b0, 1'b0);
		add_token("N", 32'd1, 1'b0, 1'b0);
		add_token(TOK_PLUS, $urandom, 1'b1, 1'b0);
		// truncation toward zero, odd codes divide, entry left below the top
		add_token("k", 32'd42, 1'b0, 1'b0);
		add_token("p", -32'sd100, 1'b0, 1'b0);
		add_token("q", 32'd7, 1'b0, 1'b0);
		add_token(TOK_LBRACKET, $urandom, 1'b0, 1'b0);
		add_token("r", 32'd3, 1'b0, 1'b0);
		add_token(TOK_BACKTICK, $urandom, 1'b0, 1'b0);
		add_token("s", 32'd9, 1'b0, 1'b0);
		add_token(TOK_MINUS, $urandom, 1'b1, 1'b0);
		add_token("E", 32'd6, 1'b0, 1'b0);
		add_token("F", 32'd4, 1'b0, 1'b0);
		add_token(TOK_LBRACE, $urandom, 1'b0, 1'b0);
		add_token(TOK_ALL_ONES, $urandom, 1'b1, 1'b0);
		// one entry under an operator, then a lone letter
		add_token("G", $urandom, 1'b0, 1'b0);
		add_token(TOK_NUL, $urandom, 1'b1, 1'b0);
		add_token("Q", $urandom, 1'b1, 1'b0);

		stop_at = n_planned + RANDOM_TOKENS;
		gen_expression(4, 1'b1);
		gen_deep(STACK_DEPTH, 3);
		gen_deep(STACK_DEPTH + 3, 2);
		while (n_planned < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				gen_expression($urandom_range(1, 8), $urandom_range(0, 29) == 0);
			else if (r < 80)
				gen_expression($urandom_range(9, 24), 1'b0);
			else
				gen_noise($urandom_range(1, 10));
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (n_accepted < n_planned)
			@(posedge clk);
		while (result_q.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);

		$display("%0d tokens, %0d results: %0d ok, %0d underflow, %0d overflow, %0d div by zero",
			n_accepted, n_status[0] + n_status[1] + n_status[2] + n_status[3],
			n_status[STAT_OK], n_status[STAT_UNDER], n_status[STAT_OVER], n_status[STAT_DIVZ]);
		if (n_fail == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/pev_pkg.sv
rtl/core/pev_stack.sv
rtl/core/pev_ctrl.sv
rtl/core/pev_datapath.sv
rtl/core/postfix_expression_evaluator.sv
bench/postfix_expression_evaluator_tb.sv
